// File: rtl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants of the modulated feedback delay: register
// indexes, controller states and the command and status bundles.
// ----------------------------------------------------------------------------
package mfd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SAMPLE_W   = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DELAY    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WET_GAIN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP    = 3'd4;

    localparam logic [22:0] BASE_DELAY_RESET = 23'd256;

    typedef enum logic [9:0] {
        ST_IDLE   = 10'b00_0000_0001,
        ST_SINE   = 10'b00_0000_0010,
        ST_MOD    = 10'b00_0000_0100,
        ST_DELAY  = 10'b00_0000_1000,
        ST_ADDR   = 10'b00_0001_0000,
        ST_READ   = 10'b00_0010_0000,
        ST_INTERP = 10'b00_0100_0000,
        ST_MIX    = 10'b00_1000_0000,
        ST_GAIN   = 10'b01_0000_0000,
        ST_WRITE  = 10'b10_0000_0000
    } t_state;

    typedef struct packed {
        logic accept;
        logic sine_en;
        logic mod_en;
        logic delay_en;
        logic addr_en;
        logic read_en;
        logic interp_en;
        logic mix_en;
        logic gain_en;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic wet_zero;
        logic out_free;
    } t_status;

endpackage

// File: rtl/mfd_ctrl.sv
// ----------------------------------------------------------------------------
// mfd_ctrl
// Modulated feedback delay sequencer: walks a sample through the datapath
// steps, or at zero wet gain straight to commit; commit waits for a free output.
// ----------------------------------------------------------------------------
module mfd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mfd_pkg::t_status  i_status,
    output logic              o_in_ready,
    output mfd_pkg::t_cmd     o_cmd
);

    mfd_pkg::t_state r_state;
    mfd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mfd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            mfd_pkg::ST_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = i_status.wet_zero ? mfd_pkg::ST_WRITE : mfd_pkg::ST_SINE;
                end
            end
            mfd_pkg::ST_SINE: begin
                o_cmd.sine_en = 1'b1;
                n_state       = mfd_pkg::ST_MOD;
            end
            mfd_pkg::ST_MOD: begin
                o_cmd.mod_en = 1'b1;
                n_state      = mfd_pkg::ST_DELAY;
            end
            mfd_pkg::ST_DELAY: begin
                o_cmd.delay_en = 1'b1;
                n_state        = mfd_pkg::ST_ADDR;
            end
            mfd_pkg::ST_ADDR: begin
                o_cmd.addr_en = 1'b1;
                n_state       = mfd_pkg::ST_READ;
            end
            mfd_pkg::ST_READ: begin
                o_cmd.read_en = 1'b1;
                n_state       = mfd_pkg::ST_INTERP;
            end
            mfd_pkg::ST_INTERP: begin
                o_cmd.interp_en = 1'b1;
                n_state         = mfd_pkg::ST_MIX;
            end
            mfd_pkg::ST_MIX: begin
                o_cmd.mix_en = 1'b1;
                n_state      = mfd_pkg::ST_GAIN;
            end
            mfd_pkg::ST_GAIN: begin
                o_cmd.gain_en = 1'b1;
                n_state       = mfd_pkg::ST_WRITE;
            end
            mfd_pkg::ST_WRITE: begin
                // hold until the output register can take the result
                o_cmd.commit = i_status.out_free;
                if (i_status.out_free) begin
                    n_state = mfd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mfd_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == mfd_pkg::ST_IDLE);

endmodule

// File: rtl/mfd_dp.sv
// ----------------------------------------------------------------------------
// mfd_dp
// Datapath of the modulated feedback delay: registers, LFO phase and sine
// ROM, delay clamp, circular store with two read ports, interpolation,
// gains, saturation and the output register.
// ----------------------------------------------------------------------------
module mfd_dp #(
    parameter int BUFFER_DEPTH     = 32768,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic signed [mfd_pkg::SAMPLE_W-1:0] i_in_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [mfd_pkg::SAMPLE_W-1:0] o_out_sample,
    input  mfd_pkg::t_cmd                       i_cmd,
    output mfd_pkg::t_status                    o_status
);

    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int IW   = $clog2(SINE_TABLE_DEPTH);
    localparam int PW   = 32 + IW + 1;
    localparam int CW   = (AW + 10 > 26) ? AW + 10 : 26;
    localparam int RW   = AW + 9;
    localparam int SW   = mfd_pkg::SAMPLE_W;

    localparam logic signed [CW-1:0] DELAY_LO = CW'(256);
    localparam logic signed [CW-1:0] DELAY_HI = CW'((BUFFER_DEPTH - 2) * 256);
    localparam logic signed [RW-1:0] SPAN     = RW'(BUFFER_DEPTH * 256);
    localparam logic [AW-1:0]        LAST_IDX = AW'(BUFFER_DEPTH - 1);

    localparam logic signed [26:0] SAT_HI = 27'sd8388607;
    localparam logic signed [26:0] SAT_LO = -27'sd8388608;

    function automatic logic signed [15:0] sine_of_turn(input logic [15:0] turn);
        logic [1:0]  quad;
        logic [13:0] rem;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] p;
        logic [63:0] s;
        quad = turn[15:14];
        rem  = turn[13:0];
        x    = quad[0] ? (64'd16384 - 64'(rem)) : 64'(rem);
        x2   = (x * x) >> 14;
        p    = 64'd21167 - ((x2 * 64'd2611) >> 14);
        p    = 64'd51472 - ((x2 * p) >> 14);
        s    = (x * p) >> 14;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return quad[1] ? -$signed(s[15:0]) : $signed(s[15:0]);
    endfunction

    function automatic logic signed [SW-1:0] sat_sample(input logic signed [26:0] v);
        if (v > SAT_HI) begin
            return SAT_HI[SW-1:0];
        end else if (v < SAT_LO) begin
            return SAT_LO[SW-1:0];
        end
        return v[SW-1:0];
    endfunction

    // configuration and control state
    logic [22:0] r_base_delay;
    logic [21:0] r_mod_depth;
    logic [15:0] r_feedback_gain;
    logic [15:0] r_wet_gain;
    logic [31:0] r_phase_step;
    logic [31:0] r_phase;
    logic [AW-1:0] r_wi;
    logic        r_filled;
    logic        r_out_valid;

    // payload
    logic signed [SW-1:0] r_x;
    logic [PW-1:0]        r_prod;
    logic signed [15:0]   r_sine;
    logic signed [38:0]   r_mod;
    logic [AW+7:0]        r_delay;
    logic [AW-1:0]        r_i0;
    logic [AW-1:0]        r_i1;
    logic [7:0]           r_frac;
    logic                 r_v0;
    logic                 r_v1;
    logic signed [SW-1:0] r_y0;
    logic signed [SW-1:0] r_y1;
    logic signed [33:0]   r_interp;
    logic signed [SW-1:0] r_delayed;
    logic signed [40:0]   r_fb_prod;
    logic signed [40:0]   r_wet_prod;
    logic signed [SW-1:0] r_out_sample;
    logic signed [SW-1:0] r_mem [BUFFER_DEPTH];

    logic signed [15:0]   w_rom [SINE_TABLE_DEPTH];
    logic signed [CW-1:0] w_sum;
    logic signed [CW-1:0] w_clamp;
    logic signed [RW-1:0] w_rp;
    logic [RW-1:0]        w_rpw;
    logic [AW-1:0]        w_i0;
    logic [AW-1:0]        w_i1;
    logic signed [SW-1:0] w_y0m;
    logic signed [SW-1:0] w_y1m;
    logic signed [24:0]   w_diff;
    logic signed [25:0]   w_mix;
    logic signed [26:0]   w_fb_sum;
    logic signed [26:0]   w_wet_sum;
    logic signed [SW-1:0] w_fb_sat;
    logic                 w_wet_zero;

    genvar g;
    for (g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [15:0] TURN = 16'((g * 65536) / SINE_TABLE_DEPTH);
        assign w_rom[g] = sine_of_turn(TURN);
    end

    assign w_wet_zero = (r_wet_gain == 16'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_delay    <= mfd_pkg::BASE_DELAY_RESET;
            r_mod_depth     <= '0;
            r_feedback_gain <= '0;
            r_wet_gain      <= '0;
            r_phase_step    <= '0;
            r_phase         <= '0;
            r_wi            <= '0;
            r_filled        <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mfd_pkg::CFG_BASE_DELAY:    r_base_delay    <= i_cfg_data[22:0];
                    mfd_pkg::CFG_MOD_DEPTH:     r_mod_depth     <= i_cfg_data[21:0];
                    mfd_pkg::CFG_FEEDBACK_GAIN: r_feedback_gain <= i_cfg_data[15:0];
                    mfd_pkg::CFG_WET_GAIN:      r_wet_gain      <= i_cfg_data[15:0];
                    mfd_pkg::CFG_PHASE_STEP:    r_phase_step    <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept && !w_wet_zero) begin
                r_phase <= r_phase + r_phase_step;
            end
            if (i_cmd.commit && !w_wet_zero) begin
                if (r_wi == LAST_IDX) begin
                    r_wi     <= '0;
                    r_filled <= 1'b1;
                end else begin
                    r_wi <= r_wi + 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // delay: base plus LFO swing, clamped to the usable span of the store
    assign w_sum = $signed({{(CW-23){1'b0}}, r_base_delay})
                 + $signed({{(CW-24){r_mod[38]}}, r_mod[38:15]});

    always_comb begin
        if (w_sum > DELAY_HI) begin
            w_clamp = DELAY_HI;
        end else if (w_sum < DELAY_LO) begin
            w_clamp = DELAY_LO;
        end else begin
            w_clamp = w_sum;
        end
    end

    // read position behind the write pointer, wrapped into the store
    assign w_rp  = $signed({1'b0, r_wi, 8'd0}) - $signed({1'b0, r_delay});
    assign w_rpw = w_rp[RW-1] ? (w_rp + SPAN) : w_rp;
    assign w_i0  = w_rpw[AW+7:8];
    assign w_i1  = (w_i0 == LAST_IDX) ? '0 : (w_i0 + 1'b1);

    // entries not yet written since reset read as zero
    assign w_y0m  = r_v0 ? r_y0 : '0;
    assign w_y1m  = r_v1 ? r_y1 : '0;
    assign w_diff = $signed({w_y1m[SW-1], w_y1m}) - $signed({w_y0m[SW-1], w_y0m});
    assign w_mix  = $signed({{2{w_y0m[SW-1]}}, w_y0m}) + $signed(r_interp[33:8]);

    assign w_fb_sum  = $signed({{3{r_x[SW-1]}}, r_x})
                     + $signed({{2{r_fb_prod[40]}}, r_fb_prod[40:16]});
    assign w_wet_sum = $signed({{3{r_x[SW-1]}}, r_x})
                     + $signed({r_wet_prod[40], r_wet_prod[40:15]});
    assign w_fb_sat  = sat_sample(w_fb_sum);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_x    <= i_in_sample;
            r_prod <= PW'(r_phase) * PW'(SINE_TABLE_DEPTH);
        end
        if (i_cmd.sine_en) begin
            r_sine <= w_rom[r_prod[32 +: IW]];
        end
        if (i_cmd.mod_en) begin
            r_mod <= $signed({{23{r_sine[15]}}, r_sine}) * $signed({17'd0, r_mod_depth});
        end
        if (i_cmd.delay_en) begin
            r_delay <= w_clamp[AW+7:0];
        end
        if (i_cmd.addr_en) begin
            r_i0   <= w_i0;
            r_i1   <= w_i1;
            r_frac <= w_rpw[7:0];
            r_v0   <= r_filled || (w_i0 < r_wi);
            r_v1   <= r_filled || (w_i1 < r_wi);
        end
        if (i_cmd.interp_en) begin
            r_interp <= $signed({26'd0, r_frac}) * $signed({{9{w_diff[24]}}, w_diff});
        end
        if (i_cmd.mix_en) begin
            r_delayed <= w_mix[SW-1:0];
        end
        if (i_cmd.gain_en) begin
            r_fb_prod  <= $signed({{17{r_delayed[SW-1]}}, r_delayed})
                        * $signed({25'd0, r_feedback_gain});
            r_wet_prod <= $signed({{17{r_delayed[SW-1]}}, r_delayed})
                        * $signed({25'd0, r_wet_gain});
        end
        if (i_cmd.commit) begin
            r_out_sample <= w_wet_zero ? r_x : sat_sample(w_wet_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read_en) begin
            r_y0 <= r_mem[r_i0];
            r_y1 <= r_mem[r_i1];
        end
        if (i_cmd.commit && !w_wet_zero) begin
            r_mem[r_wi] <= w_fb_sat;
        end
    end

    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_out_sample      = r_out_sample;
    assign o_status.wet_zero = w_wet_zero;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule

// File: rtl/modulated_feedback_delay.sv
// ----------------------------------------------------------------------------
// modulated_feedback_delay
// Modulated delay line with feedback: sine LFO swings the delay, the store
// is read with linear interpolation, and feedback and wet mix saturate.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------
//  in       | input     | i_in_valid / o_in_ready   | i_in_sample  (s24 Q1.23)
//  out      | output    | o_out_valid / i_out_ready | o_out_sample (s24 Q1.23)
//  cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  A sample goes from transaction to result through the chain of sequencer
//  steps: phase, sine ROM, swing multiply, clamp, address, store read,
//  interpolate, mix, gain multiplies, commit. Bypass goes straight to commit.
//  One sample is in flight at a time; a new transaction is taken the cycle
//  after commit. Commit holds while the output register is full and stalled.
//  Reset is synchronous; no clearing pass, samples are taken right after it.
// ----------------------------------------------------------------------------
module modulated_feedback_delay #(
    parameter int BUFFER_DEPTH     = 32768,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [mfd_pkg::SAMPLE_W-1:0] i_in_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [mfd_pkg::SAMPLE_W-1:0] o_out_sample
);

    mfd_pkg::t_cmd    w_cmd;
    mfd_pkg::t_status w_status;

    mfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    mfd_dp #(
        .BUFFER_DEPTH     (BUFFER_DEPTH),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_sample  (i_in_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_sample (o_out_sample),
        .i_cmd        (w_cmd),
        .o_status     (w_status)
    );

endmodule

// File: dv/modulated_feedback_delay_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modulated_feedback_delay_tb
// Drives samples and register writes into the modulated feedback delay and
// checks every output sample against a bit-exact model of the delay line,
// sine LFO, interpolation and saturating feedback and wet mix.
// ----------------------------------------------------------------------------
module modulated_feedback_delay_tb;

    localparam int LINE_DEPTH = 32768;
    localparam longint LINE_SPAN = longint'(LINE_DEPTH) * 256;
    localparam longint DELAY_MIN = 256;
    localparam longint DELAY_MAX = longint'(LINE_DEPTH - 2) * 256;
    localparam int STALL_CYCLES = 400;

    class delay_line_tracker;
        logic signed [mfd_pkg::SAMPLE_W-1:0] line_mem [LINE_DEPTH];
        logic signed [mfd_pkg::SAMPLE_W-1:0] expected_out [$];
        int          write_ptr;
        logic [31:0] lfo_phase;
        longint      base_delay;
        longint      mod_depth;
        longint      feedback_gain;
        longint      wet_gain;
        logic [31:0] phase_step;
        int          errors;

        function new();
            foreach (line_mem[i]) line_mem[i] = '0;
            write_ptr     = 0;
            lfo_phase     = '0;
            base_delay    = longint'(mfd_pkg::BASE_DELAY_RESET);
            mod_depth     = 0;
            feedback_gain = 0;
            wet_gain      = 0;
            phase_step    = '0;
            errors        = 0;
        endfunction

        function void set_reg(logic [mfd_pkg::CFG_IDX_W-1:0] idx,
                              logic [mfd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                mfd_pkg::CFG_BASE_DELAY:    base_delay    = longint'(data[22:0]);
                mfd_pkg::CFG_MOD_DEPTH:     mod_depth     = longint'(data[21:0]);
                mfd_pkg::CFG_FEEDBACK_GAIN: feedback_gain = longint'(data[15:0]);
                mfd_pkg::CFG_WET_GAIN:      wet_gain      = longint'(data[15:0]);
                mfd_pkg::CFG_PHASE_STEP:    phase_step    = data;
                default: ;
            endcase
        endfunction

        function logic signed [mfd_pkg::SAMPLE_W-1:0] sat24(longint v);
            if (v > 8388607) return 24'sh7FFFFF;
            if (v < -8388608) return 24'sh800000;
            return v[mfd_pkg::SAMPLE_W-1:0];
        endfunction

        // Q1.15 sine from a quarter-wave polynomial; angle is a 16-bit turn
        function int lfo_sine(logic [9:0] idx);
            logic [15:0] ang;
            longint unsigned x, x2, p, s;
            ang = {idx, 6'b0};
            x   = ang[14] ? 64'd16384 - ang[13:0] : ang[13:0];
            x2  = (x * x) >> 14;
            p   = 21167 - ((x2 * 2611) >> 14);
            p   = 51472 - ((x2 * p) >> 14);
            s   = (x * p) >> 14;
            if (s > 32767) s = 32767;
            return ang[15] ? -int'(s) : int'(s);
        endfunction

        function logic signed [mfd_pkg::SAMPLE_W-1:0] echo_output(
            logic signed [mfd_pkg::SAMPLE_W-1:0] x);
            int     sine;
            int     i0;
            int     i1;
            longint frac;
            longint delay;
            longint rp;
            longint y0;
            longint y1;
            longint tap;
            longint fb;
            longint wet;
            sine      = lfo_sine(lfo_phase[31:22]);
            lfo_phase = lfo_phase + phase_step;
            delay = base_delay + ((longint'(sine) * mod_depth) >>> 15);
            if (delay > DELAY_MAX) delay = DELAY_MAX;
            if (delay < DELAY_MIN) delay = DELAY_MIN;
            rp = (longint'(write_ptr) * 256 - delay) % LINE_SPAN;
            if (rp < 0) rp += LINE_SPAN;
            i0   = int'((rp >> 8) % LINE_DEPTH);
            i1   = (i0 + 1) % LINE_DEPTH;
            frac = rp & 255;
            y0   = line_mem[i0];
            y1   = line_mem[i1];
            tap  = y0 + ((frac * (y1 - y0)) >>> 8);
            fb   = (tap * feedback_gain) >>> 16;
            line_mem[write_ptr] = sat24(longint'(x) + fb);
            write_ptr = (write_ptr + 1) % LINE_DEPTH;
            wet = (tap * wet_gain) >>> 15;
            return sat24(longint'(x) + wet);
        endfunction

        function void take_sample(logic signed [mfd_pkg::SAMPLE_W-1:0] x);
            if (wet_gain == 0) begin
                expected_out.push_back(x);
            end else begin
                expected_out.push_back(echo_output(x));
            end
        endfunction

        function void match_output(logic signed [mfd_pkg::SAMPLE_W-1:0] got);
            logic signed [mfd_pkg::SAMPLE_W-1:0] want;
            if (expected_out.size() == 0) begin
                $error("out_sample: expected nothing, got %0d", got);
                errors++;
                return;
            end
            want = expected_out.pop_front();
            if (got !== want) begin
                $error("out_sample: expected %0d, got %0d", want, got);
                errors++;
            end
        endfunction

        function int pending();
            return expected_out.size();
        endfunction
    endclass

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [mfd_pkg::CFG_IDX_W-1:0]       i_cfg_index;
    logic [mfd_pkg::CFG_DATA_W-1:0]      i_cfg_data;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic signed [mfd_pkg::SAMPLE_W-1:0] i_in_sample;
    logic                                o_out_valid;
    logic                                i_out_ready;
    logic signed [mfd_pkg::SAMPLE_W-1:0] o_out_sample;

    delay_line_tracker echo_model = new();
    int send_idle_pct;
    int recv_idle_pct;
    bit stall_request;

    modulated_feedback_delay u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_sample  (i_in_sample),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_sample (o_out_sample)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            echo_model.take_sample(i_in_sample);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            echo_model.match_output(o_out_sample);
        end
    end

    // Output side: random back-pressure, plus one long hold on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                stall_request = 1'b0;
                i_out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic signed [mfd_pkg::SAMPLE_W-1:0] rand_sample();
        logic [31:0]                         raw;
        logic signed [mfd_pkg::SAMPLE_W-1:0] s;
        raw = $urandom;
        s   = raw[mfd_pkg::SAMPLE_W-1:0];
        if ($urandom_range(2) == 0) return s;
        return s >>> $urandom_range(1, 10);
    endfunction

    task automatic send_sample(input logic signed [mfd_pkg::SAMPLE_W-1:0] x);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_in_sample <= x;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (echo_model.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [mfd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mfd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        echo_model.set_reg(idx, data);
    endtask

    task automatic load_settings(input logic [31:0] base, input logic [31:0] depth,
                                 input logic [31:0] fb, input logic [31:0] wet,
                                 input logic [31:0] step);
        logic [31:0]                   pick;
        logic [mfd_pkg::CFG_IDX_W-1:0] spare;
        pick  = $urandom_range(mfd_pkg::CFG_PHASE_STEP + 1, 2**mfd_pkg::CFG_IDX_W - 1);
        spare = pick[mfd_pkg::CFG_IDX_W-1:0];
        write_reg(mfd_pkg::CFG_BASE_DELAY, base);
        write_reg(mfd_pkg::CFG_MOD_DEPTH, depth);
        write_reg(mfd_pkg::CFG_FEEDBACK_GAIN, fb);
        write_reg(spare, $urandom);
        write_reg(mfd_pkg::CFG_WET_GAIN, wet);
        write_reg(mfd_pkg::CFG_PHASE_STEP, step);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_settings();
        logic [31:0] base;
        logic [31:0] depth;
        logic [31:0] fb;
        logic [31:0] wet;
        logic [31:0] step;
        case ($urandom_range(9))
            0:       base = 0;
            1:       base = 32'h007F_FFFF;
            2:       base = 8388096;
            3:       base = $urandom;
            default: base = $urandom_range(256, 48 * 256);
        endcase
        if ($urandom_range(1)) base |= $urandom & 32'hFF80_0000;
        case ($urandom_range(4))
            0:       depth = 0;
            1:       depth = 32'h003F_FFFF;
            2:       depth = $urandom;
            default: depth = $urandom_range(0, 48 * 256);
        endcase
        case ($urandom_range(4))
            0:       fb = 0;
            1:       fb = 62259;
            2:       fb = $urandom;
            default: fb = $urandom_range(0, 62259);
        endcase
        case ($urandom_range(6))
            0:       wet = 0;
            1:       wet = 32768;
            2:       wet = 32'h0000_FFFF;
            default: wet = $urandom_range(1, 32768);
        endcase
        case ($urandom_range(3))
            0:       step = 0;
            1:       step = $urandom;
            default: step = $urandom_range(0, 32'h0100_0000);
        endcase
        load_settings(base, depth, fb, wet, step);
    endtask

    initial begin
        logic signed [mfd_pkg::SAMPLE_W-1:0] bypass_set [4];
        logic signed [mfd_pkg::SAMPLE_W-1:0] corner_set [7];
        bypass_set = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'shFFFFFF};
        corner_set = '{24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh555555,
                       24'shAAAAAA, 24'sh000001, 24'sh000000};
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= '0;
        i_cfg_data    <= '0;
        i_in_valid    <= 1'b0;
        i_in_sample   <= '0;
        stall_request  = 1'b0;
        send_idle_pct  = 9;
        recv_idle_pct  = 75;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // bypass after reset: pass through, state untouched
        foreach (bypass_set[i]) send_sample(bypass_set[i]);
        wait_drained();
        // one-sample delay, top feedback, saturation
        load_settings(256, 0, 62259, 32768, 0);
        foreach (corner_set[i]) send_sample(corner_set[i]);
        wait_drained();
        // gains above range, delay clamped high, quarter-turn LFO steps
        load_settings(32'hFFFF_FFFF, 32'h003F_FFFF, 32'h0000_FFFF, 32'h0000_FFFF,
                      32'h4000_0000);
        repeat (6) send_sample(rand_sample());
        wait_drained();
        // zero base with full swing: delay clamped low
        load_settings(0, 32'h003F_FFFF, 32768, 16384, 32'h0800_0000);
        repeat (6) send_sample(rand_sample());

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin send_idle_pct = 9;  recv_idle_pct = 75; end
                1: begin send_idle_pct = 75; recv_idle_pct = 9;  end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int ph = 0; ph < 6; ph++) begin
                wait_drained();
                random_settings();
                if (mode == 2 && ph == 0) stall_request = 1'b1;
                repeat (105) send_sample(rand_sample());
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (echo_model.errors == 0 && echo_model.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/mfd_pkg.sv
rtl/mfd_ctrl.sv
rtl/mfd_dp.sv
rtl/modulated_feedback_delay.sv
dv/modulated_feedback_delay_tb.sv
